>>> src/ems_pkg.sv
// ----------------------------------------------------------------------------
// EMS mapper package
// Transaction types, command codes and control file constants shared by the
// EMS page mapper and system control block.
// ----------------------------------------------------------------------------
`default_nettype none

package ems_pkg;

    typedef logic [1:0] cmd_t;

    localparam cmd_t CMD_IO_READ  = 2'd0;
    localparam cmd_t CMD_IO_WRITE = 2'd1;
    localparam cmd_t CMD_XLATE    = 2'd2;
    localparam cmd_t CMD_KEY_UPD  = 2'd3;

    typedef struct packed {
        cmd_t        cmd;
        logic [15:0] io_port;
        logic [7:0]  data;
        logic [19:0] mem_addr;
        logic [7:0]  clear_mask;
        logic [7:0]  set_mask;
        logic [7:0]  toggle_mask;
    } req_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        port_hit;
        logic        mapped;
        logic [20:0] phys_addr;
        logic        video_option;
        logic        display_on;
        logic        turbo_on;
        logic        internal_video_on;
        logic        low_ram_640k;
    } rsp_t;

    // control file indexes
    localparam logic [3:0] IDX_KEYS     = 4'h1;
    localparam logic [3:0] IDX_UNLOCK   = 4'h3;
    localparam logic [3:0] IDX_VIDEO    = 4'h4;
    localparam logic [3:0] IDX_INT_VID  = 4'h6;
    localparam logic [3:0] IDX_EMS_FN   = 4'hE;
    localparam logic [3:0] IDX_EMS_DATA = 4'hF;

    localparam logic [11:0] CTL_PORT_BASE = 12'h00E;
    localparam logic [7:0]  UNLOCK_KEY    = 8'h5A;

    // EMS control functions
    localparam logic [7:0] FN_PORT_SEL = 8'h50;
    localparam logic [7:0] FN_HARDRAM  = 8'h51;
    localparam logic [7:0] FN_LOW_640K = 8'h52;

    localparam logic [3:0]  NO_EMS_CHOICE = 4'h7;
    localparam logic [10:0] BASE_RAM_KB   = 11'd512;
    localparam logic [10:0] RAM_640_KB    = 11'd640;
    localparam logic [3:0]  FRAME_SEG     = 4'hD;
    localparam logic [20:0] EXP_RAM_BASE  = 21'h80000;
    localparam logic [5:0]  MAX_PAGES     = 6'd63;

    // APB register indexes
    localparam logic REG_MEM_SIZE = 1'b0;
    localparam logic REG_IS_T12   = 1'b1;

endpackage

`default_nettype wire

>>> src/ems_mapper_system_control_top.sv
// ----------------------------------------------------------------------------
// EMS mapper and system control top level
// I/O decode of the system control file and EMS page registers, page frame
// translation at 0xD0000, system key update and video/turbo control lines.
// ----------------------------------------------------------------------------
//
// Usage:
//   in_valid/in_ready/in_item carry one request transaction (io read, io
//   write, page frame translate or key update). out_valid/out_ready/out_item
//   return exactly one response transaction per request, in order.
//   A request is latched in an input stage, then decoded, applied to the
//   control state and captured in the response register in one pass, so the
//   request passes the input stage register and then the response register;
//   throughput is one transaction per cycle while out_ready stays high.
//   When the receiver stalls, the response register holds and the input
//   stage holds one more request; in_ready drops only while both are full
//   and out_ready is low.
//   Reset clears the control file, page registers and key byte, disables
//   EMS with no port selected, sets display and internal video on and loads
//   512 KB of RAM with the later-model features off. The APB port sets the
//   RAM size at address 0 and the later-model enable at address 4; pready
//   is always high.
//
`default_nettype none

module ems_mapper_system_control_top #(
    parameter int FRAME_PAGES = 4
) (
    input  wire logic          clk,
    input  wire logic          rst_n,

    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire ems_pkg::req_t in_item,

    output logic               out_valid,
    input  wire logic          out_ready,
    output ems_pkg::rsp_t      out_item,

    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam logic [2:0] NUM_PAGES = 3'(FRAME_PAGES);

    // configuration
    logic [10:0] mem_size_kb_reg;
    logic        late_model_reg;

    // pipeline
    logic          stg_valid_reg;
    ems_pkg::req_t stg_item_reg;
    logic          out_valid_reg;
    ems_pkg::rsp_t out_item_reg;
    logic          res_free;
    logic          fire;

    // control state
    logic [7:0]  ctl_file_reg  [16];
    logic [7:0]  ctl_file_next [16];
    logic [7:0]  page_sel_reg  [FRAME_PAGES];
    logic [7:0]  page_sel_next [FRAME_PAGES];
    logic [20:0] page_base_reg [FRAME_PAGES];
    logic [20:0] page_base_next[FRAME_PAGES];
    logic [4:0]  hardram_reg, hardram_next;
    logic [5:0]  page_cnt_reg, page_cnt_next;
    logic [3:0]  port_choice_reg, port_choice_next;
    logic        ram_640k_reg, ram_640k_next;
    logic [7:0]  keys_reg, keys_next;
    logic        vid_option_reg, vid_option_next;
    logic        vid_display_reg, vid_display_next;
    logic        vid_turbo_reg, vid_turbo_next;
    logic        vid_internal_reg, vid_internal_next;

    ems_pkg::rsp_t rsp;

    // decode
    logic        is_io;
    logic        ctl_hit;
    logic        ems_hit;
    logic [1:0]  port_pg;
    logic [3:0]  ctl_idx;
    logic [7:0]  ctl_rd;
    logic [7:0]  sel_rd;
    logic [7:0]  wr_data;
    logic        size_ext;
    logic [6:0]  ext_16k;
    logic [4:0]  hb_new;
    logic signed [8:0] pages_raw;
    logic        in_frame;
    logic [1:0]  frame_pg;
    logic [20:0] frame_base;

    function automatic logic [20:0] page_addr(
        input logic [7:0] sel,
        input logic [4:0] hb,
        input logic [5:0] cnt
    );
        logic [20:0] res;
        res = 21'd0;
        if (sel[7] && cnt != 6'd0 && sel[6:0] < {1'b0, cnt})
        begin
            res = ems_pkg::EXP_RAM_BASE + {hb, 16'h0000} + {sel[6:0], 14'h0000};
        end
        return res;
    endfunction

    assign pready    = 1'b1;
    assign res_free  = !out_valid_reg || out_ready;
    assign in_ready  = !stg_valid_reg || res_free;
    assign fire      = stg_valid_reg && res_free;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_comb
    begin
        if (paddr[2] == ems_pkg::REG_IS_T12)
        begin
            prdata = {31'd0, late_model_reg};
        end
        else
        begin
            prdata = {21'd0, mem_size_kb_reg};
        end
    end

    assign is_io    = stg_item_reg.cmd == ems_pkg::CMD_IO_READ ||
                      stg_item_reg.cmd == ems_pkg::CMD_IO_WRITE;
    assign ctl_idx  = stg_item_reg.io_port[3:0];
    assign wr_data  = stg_item_reg.data;
    assign ctl_hit  = is_io && stg_item_reg.io_port[15:4] == ems_pkg::CTL_PORT_BASE;
    assign port_pg  = stg_item_reg.io_port[15:14];
    assign ems_hit  = is_io && !ctl_hit && port_choice_reg != ems_pkg::NO_EMS_CHOICE &&
                      stg_item_reg.io_port[13:0] ==
                      {4'b0000, 2'b10, port_choice_reg, 4'b1000} &&
                      {1'b0, port_pg} < NUM_PAGES;
    assign size_ext = mem_size_kb_reg > ems_pkg::BASE_RAM_KB;
    assign ext_16k  = 7'((mem_size_kb_reg - ems_pkg::BASE_RAM_KB) >> 4);
    assign hb_new   = size_ext ? wr_data[4:0] : 5'd0;
    assign pages_raw = $signed({2'b00, ext_16k}) - $signed({2'b00, hb_new, 2'b00});
    assign in_frame = stg_item_reg.mem_addr[19:16] == ems_pkg::FRAME_SEG &&
                      {1'b0, stg_item_reg.mem_addr[15:14]} < NUM_PAGES;
    assign frame_pg = stg_item_reg.mem_addr[15:14];

    always_comb
    begin
        sel_rd     = 8'h00;
        frame_base = 21'd0;
        for (int n = 0; n < FRAME_PAGES; n++)
        begin
            if (port_pg == 2'(n))
            begin
                sel_rd = page_sel_reg[n];
            end
            if (frame_pg == 2'(n))
            begin
                frame_base = page_base_reg[n];
            end
        end
    end

    always_comb
    begin
        if (ctl_idx == ems_pkg::IDX_KEYS)
        begin
            ctl_rd = keys_reg;
        end
        else if (ctl_idx != ems_pkg::IDX_EMS_DATA)
        begin
            ctl_rd = ctl_file_reg[ctl_idx];
        end
        else
        begin
            case (ctl_file_reg[ems_pkg::IDX_EMS_FN])
                ems_pkg::FN_PORT_SEL: ctl_rd = size_ext ? {4'h9, port_choice_reg} : 8'hFF;
                ems_pkg::FN_HARDRAM:  ctl_rd = {3'b011, hardram_reg};
                ems_pkg::FN_LOW_640K: ctl_rd = {ram_640k_reg, 7'd0};
                default:              ctl_rd = 8'hFF;
            endcase
        end
    end

    always_comb
    begin
        ctl_file_next     = ctl_file_reg;
        page_sel_next     = page_sel_reg;
        page_base_next    = page_base_reg;
        hardram_next      = hardram_reg;
        page_cnt_next     = page_cnt_reg;
        port_choice_next  = port_choice_reg;
        ram_640k_next     = ram_640k_reg;
        keys_next         = keys_reg;
        vid_option_next   = vid_option_reg;
        vid_display_next  = vid_display_reg;
        vid_turbo_next    = vid_turbo_reg;
        vid_internal_next = vid_internal_reg;

        rsp = '0;
        rsp.read_data = 8'hFF;

        case (stg_item_reg.cmd)
            ems_pkg::CMD_IO_READ:
            begin
                if (ctl_hit)
                begin
                    rsp.port_hit  = 1'b1;
                    rsp.read_data = ctl_rd;
                end
                else if (ems_hit)
                begin
                    rsp.port_hit  = 1'b1;
                    rsp.read_data = sel_rd;
                end
            end
            ems_pkg::CMD_IO_WRITE:
            begin
                if (ctl_hit)
                begin
                    rsp.port_hit = 1'b1;
                    ctl_file_next[ctl_idx] = wr_data;
                    if (ctl_idx == ems_pkg::IDX_VIDEO)
                    begin
                        if (ctl_file_reg[ems_pkg::IDX_UNLOCK] == ems_pkg::UNLOCK_KEY)
                        begin
                            vid_option_next  = wr_data[5];
                            vid_display_next = !wr_data[6];
                            if (late_model_reg)
                            begin
                                vid_turbo_next = wr_data[7];
                            end
                        end
                    end
                    else if (ctl_idx == ems_pkg::IDX_INT_VID)
                    begin
                        if (late_model_reg)
                        begin
                            vid_internal_next = !wr_data[0];
                        end
                    end
                    else if (ctl_idx == ems_pkg::IDX_EMS_DATA)
                    begin
                        case (ctl_file_reg[ems_pkg::IDX_EMS_FN])
                            ems_pkg::FN_PORT_SEL: port_choice_next = wr_data[3:0];
                            ems_pkg::FN_HARDRAM:
                            begin
                                hardram_next = hb_new;
                                if (!size_ext || pages_raw < 0)
                                begin
                                    page_cnt_next = 6'd0;
                                end
                                else if (pages_raw > $signed({3'b000, ems_pkg::MAX_PAGES}))
                                begin
                                    page_cnt_next = ems_pkg::MAX_PAGES;
                                end
                                else
                                begin
                                    page_cnt_next = pages_raw[5:0];
                                end
                                for (int n = 0; n < FRAME_PAGES; n++)
                                begin
                                    page_base_next[n] = page_addr(page_sel_reg[n],
                                                                  hardram_next,
                                                                  page_cnt_next);
                                end
                            end
                            ems_pkg::FN_LOW_640K:
                                ram_640k_next = wr_data != 8'h00 &&
                                                mem_size_kb_reg >= ems_pkg::RAM_640_KB;
                            default: ;
                        endcase
                    end
                end
                else if (ems_hit)
                begin
                    rsp.port_hit = 1'b1;
                    for (int n = 0; n < FRAME_PAGES; n++)
                    begin
                        if (port_pg == 2'(n))
                        begin
                            page_sel_next[n]  = wr_data;
                            page_base_next[n] = page_addr(wr_data, hardram_reg, page_cnt_reg);
                        end
                    end
                end
            end
            ems_pkg::CMD_XLATE:
            begin
                if (in_frame && frame_base != 21'd0)
                begin
                    rsp.mapped    = 1'b1;
                    rsp.phys_addr = frame_base + {7'd0, stg_item_reg.mem_addr[13:0]};
                end
            end
            default:
            begin
                keys_next = ((keys_reg & ~stg_item_reg.clear_mask) | stg_item_reg.set_mask) ^
                            stg_item_reg.toggle_mask;
            end
        endcase

        rsp.video_option      = vid_option_next;
        rsp.display_on        = vid_display_next;
        rsp.turbo_on          = vid_turbo_next;
        rsp.internal_video_on = vid_internal_next;
        rsp.low_ram_640k      = ram_640k_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_size_kb_reg  <= ems_pkg::BASE_RAM_KB;
            late_model_reg   <= 1'b0;
            stg_valid_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
            ctl_file_reg     <= '{default: 8'h00};
            page_sel_reg     <= '{default: 8'h00};
            page_base_reg    <= '{default: 21'd0};
            hardram_reg      <= 5'd0;
            page_cnt_reg     <= 6'd0;
            port_choice_reg  <= ems_pkg::NO_EMS_CHOICE;
            ram_640k_reg     <= 1'b0;
            keys_reg         <= 8'h00;
            vid_option_reg   <= 1'b0;
            vid_display_reg  <= 1'b1;
            vid_turbo_reg    <= 1'b0;
            vid_internal_reg <= 1'b1;
        end
        else
        begin
            if (psel && penable && pwrite)
            begin
                if (paddr[2] == ems_pkg::REG_IS_T12)
                begin
                    late_model_reg <= pwdata[0];
                end
                else
                begin
                    mem_size_kb_reg <= pwdata[10:0];
                end
            end
            if (in_ready)
            begin
                stg_valid_reg <= in_valid;
            end
            if (fire)
            begin
                out_valid_reg    <= 1'b1;
                ctl_file_reg     <= ctl_file_next;
                page_sel_reg     <= page_sel_next;
                page_base_reg    <= page_base_next;
                hardram_reg      <= hardram_next;
                page_cnt_reg     <= page_cnt_next;
                port_choice_reg  <= port_choice_next;
                ram_640k_reg     <= ram_640k_next;
                keys_reg         <= keys_next;
                vid_option_reg   <= vid_option_next;
                vid_display_reg  <= vid_display_next;
                vid_turbo_reg    <= vid_turbo_next;
                vid_internal_reg <= vid_internal_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            stg_item_reg <= in_item;
        end
        if (fire)
        begin
            out_item_reg <= rsp;
        end
    end

    a_hit_not_mapped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_item.port_hit && out_item.mapped))
        else $error("response both decoded an io port and mapped a frame page");

    a_mapped_in_exp_ram: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.mapped |-> out_item.phys_addr >= ems_pkg::EXP_RAM_BASE)
        else $error("mapped page frame address below expansion RAM");

    a_ems_off_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        fire && is_io && !ctl_hit && port_choice_reg == ems_pkg::NO_EMS_CHOICE
        |=> !out_item.port_hit)
        else $error("EMS port decoded while EMS is disabled");

    a_stall_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> stg_valid_reg && out_valid_reg && !out_ready)
        else $error("input stalled without a held response");

endmodule

`default_nettype wire
